### rtl/tlpt_pkg.sv
package tlpt_pkg;

    localparam int ADDR_BITS  = 16;
    localparam int FRAME_BITS = 8;
    localparam int NFF_BITS   = 9;
    localparam int COUNT_BITS = 32;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_ACCEPT,
        ST_RESOLVE
    } t_state;

    typedef struct packed {
        logic                  hit;
        logic [FRAME_BITS-1:0] frame;
    } t_tlb_lookup;

    typedef struct packed {
        logic en;
        logic hit;
    } t_tlb_update;

endpackage

### rtl/tlpt_page_table.sv
module tlpt_page_table import tlpt_pkg::*; #(
    parameter int PAGE_COUNT = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(PAGE_COUNT)-1:0] i_rd_addr,
    output logic                          o_rd_valid,
    output logic [FRAME_BITS-1:0]         o_rd_frame,
    input  logic                          i_wr_en,
    input  logic [$clog2(PAGE_COUNT)-1:0] i_wr_addr,
    input  logic [FRAME_BITS-1:0]         i_wr_frame,
    output logic                          o_ready
);

    localparam int PAGE_BITS = $clog2(PAGE_COUNT);
    localparam logic [PAGE_BITS-1:0] LAST_PAGE = PAGE_BITS'(PAGE_COUNT - 1);

    logic [FRAME_BITS:0]  r_mem [PAGE_COUNT];
    logic [FRAME_BITS:0]  r_rd_data;
    logic                 r_clearing;
    logic [PAGE_BITS-1:0] r_clr_idx;

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == LAST_PAGE) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= {1'b1, i_wr_frame};
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_valid = r_rd_data[FRAME_BITS];
    assign o_rd_frame = r_rd_data[FRAME_BITS-1:0];
    assign o_ready    = !r_clearing;

endmodule

### rtl/tlpt_tlb.sv
module tlpt_tlb import tlpt_pkg::*; #(
    parameter int TLB_ENTRIES = 16,
    parameter int PAGE_BITS   = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [PAGE_BITS-1:0]  i_page,
    input  t_tlb_update           i_upd,
    input  logic [FRAME_BITS-1:0] i_fill_frame,
    output t_tlb_lookup           o_lookup
);

    localparam int IDX_BITS = $clog2(TLB_ENTRIES);
    localparam logic [IDX_BITS-1:0] RANK_MAX = IDX_BITS'(TLB_ENTRIES - 1);

    logic [PAGE_BITS-1:0]  r_page  [TLB_ENTRIES];
    logic [FRAME_BITS-1:0] r_frame [TLB_ENTRIES];
    logic [IDX_BITS-1:0]   r_rank  [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] r_valid;

    logic [TLB_ENTRIES-1:0] w_hit_vec;
    logic [IDX_BITS-1:0]    w_hit_idx;
    logic                   w_found_inv;
    logic [IDX_BITS-1:0]    w_inv_idx;
    logic [IDX_BITS-1:0]    w_lru_idx;
    logic [IDX_BITS-1:0]    w_target;
    logic [IDX_BITS-1:0]    w_old_rank;
    logic                   w_was_valid;

    always_comb begin
        w_hit_vec   = '0;
        w_hit_idx   = '0;
        w_found_inv = 1'b0;
        w_inv_idx   = '0;
        w_lru_idx   = '0;
        for (int j = 0; j < TLB_ENTRIES; j++) begin
            w_hit_vec[j] = r_valid[j] && (r_page[j] == i_page);
        end
        // lowest index wins
        for (int j = TLB_ENTRIES - 1; j >= 0; j--) begin
            if (w_hit_vec[j]) begin
                w_hit_idx = IDX_BITS'(j);
            end
            if (!r_valid[j]) begin
                w_found_inv = 1'b1;
                w_inv_idx   = IDX_BITS'(j);
            end
            if (r_rank[j] == RANK_MAX) begin
                w_lru_idx = IDX_BITS'(j);
            end
        end
    end

    always_comb begin
        if (i_upd.hit) begin
            w_target = w_hit_idx;
        end else if (w_found_inv) begin
            w_target = w_inv_idx;
        end else begin
            w_target = w_lru_idx;
        end
        w_old_rank  = r_rank[w_target];
        w_was_valid = r_valid[w_target];
    end

    assign o_lookup.hit   = |w_hit_vec;
    assign o_lookup.frame = r_frame[w_hit_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int j = 0; j < TLB_ENTRIES; j++) begin
                r_rank[j] <= '0;
            end
        end else if (i_upd.en) begin
            for (int j = 0; j < TLB_ENTRIES; j++) begin
                if (IDX_BITS'(j) == w_target) begin
                    r_rank[j]  <= '0;
                    r_valid[j] <= 1'b1;
                end else if (r_valid[j] && (!w_was_valid || r_rank[j] < w_old_rank)) begin
                    r_rank[j] <= r_rank[j] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.en && !i_upd.hit) begin
            r_page[w_target]  <= i_page;
            r_frame[w_target] <= i_fill_frame;
        end
    end

endmodule

### rtl/tlb_lru_page_translator.sv
// Translates a 16-bit logical address (page above OFFSET_BITS, offset below) through a
// TLB_ENTRIES-entry fully associative TLB with LRU replacement, backed by a PAGE_COUNT-entry
// page table in one synchronous memory; unmapped pages get the next free frame in order.
// PAGE_COUNT must be a power of two, the page number is taken modulo PAGE_COUNT. After reset
// the page table is swept clear and no item is accepted during the sweep. Each item then
// passes through ST_ACCEPT, which captures the address and reads the page table, and
// ST_RESOLVE, which compares the TLB, resolves the frame and writes back the table and the
// LRU ranks. A result that is not taken holds the next item in ST_RESOLVE until it leaves
// the output register. Result tuser bit 0 is the TLB hit flag, bit 1 the page fault flag.
module tlb_lru_page_translator import tlpt_pkg::*; #(
    parameter int TLB_ENTRIES = 16,
    parameter int PAGE_COUNT  = 256,
    parameter int OFFSET_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // logical_address
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [79:0] o_m_axis_tdata,   // physical_address, hit_total, fault_total
    output logic [1:0]  o_m_axis_tuser    // tlb_hit, page_fault
);

    localparam int PAGE_BITS = $clog2(PAGE_COUNT);

    t_state r_state;
    t_state n_state;

    logic [PAGE_BITS-1:0]   r_page;
    logic [OFFSET_BITS-1:0] r_offset;
    logic [NFF_BITS-1:0]    r_nff;
    logic [COUNT_BITS-1:0]  r_hit_cnt;
    logic [COUNT_BITS-1:0]  r_fault_cnt;
    logic                   r_out_valid;
    logic [79:0]            r_out_data;
    logic [1:0]             r_out_user;

    logic [31:0]            w_shifted;
    logic [PAGE_BITS-1:0]   w_in_page;
    logic [PAGE_BITS-1:0]   w_rd_addr;
    logic                   w_tbl_ready;
    logic                   w_tbl_valid;
    logic [FRAME_BITS-1:0]  w_tbl_frame;
    t_tlb_lookup            w_lookup;
    t_tlb_update            w_upd;
    logic                   w_accept;
    logic                   w_proceed;
    logic                   w_fault;
    logic [FRAME_BITS-1:0]  w_frame;
    logic [31:0]            w_phys;
    logic [COUNT_BITS-1:0]  w_hit_next;
    logic [COUNT_BITS-1:0]  w_fault_next;

    assign w_shifted = {16'b0, i_s_axis_tdata} >> OFFSET_BITS;
    assign w_in_page = w_shifted[PAGE_BITS-1:0];
    assign w_rd_addr = (r_state == ST_ACCEPT) ? w_in_page : r_page;

    tlpt_page_table #(
        .PAGE_COUNT(PAGE_COUNT)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr  (w_rd_addr),
        .o_rd_valid (w_tbl_valid),
        .o_rd_frame (w_tbl_frame),
        .i_wr_en    (w_proceed && w_fault),
        .i_wr_addr  (r_page),
        .i_wr_frame (w_frame),
        .o_ready    (w_tbl_ready)
    );

    tlpt_tlb #(
        .TLB_ENTRIES(TLB_ENTRIES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_tlb (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_page       (r_page),
        .i_upd        (w_upd),
        .i_fill_frame (w_frame),
        .o_lookup     (w_lookup)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (w_tbl_ready) begin
                    n_state = ST_ACCEPT;
                end
            end
            ST_ACCEPT: begin
                if (i_s_axis_tvalid) begin
                    n_state = ST_RESOLVE;
                end
            end
            ST_RESOLVE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_state = ST_ACCEPT;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        w_accept  = 1'b0;
        w_proceed = 1'b0;
        case (r_state)
            ST_ACCEPT: begin
                w_accept = i_s_axis_tvalid;
            end
            ST_RESOLVE: begin
                w_proceed = !r_out_valid || i_m_axis_tready;
            end
            default: begin
                w_accept  = 1'b0;
                w_proceed = 1'b0;
            end
        endcase
    end

    assign o_s_axis_tready = (r_state == ST_ACCEPT);

    always_comb begin
        w_fault = !w_lookup.hit && !w_tbl_valid;
        if (w_lookup.hit) begin
            w_frame = w_lookup.frame;
        end else if (w_tbl_valid) begin
            w_frame = w_tbl_frame;
        end else begin
            w_frame = r_nff[FRAME_BITS-1:0];
        end
        w_upd.en     = w_proceed;
        w_upd.hit    = w_lookup.hit;
        w_phys       = ({24'b0, w_frame} << OFFSET_BITS) | 32'(r_offset);
        w_hit_next   = r_hit_cnt + COUNT_BITS'(w_lookup.hit);
        w_fault_next = r_fault_cnt + COUNT_BITS'(w_fault);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_nff       <= '0;
            r_hit_cnt   <= '0;
            r_fault_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_proceed) begin
                r_out_valid <= 1'b1;
                r_hit_cnt   <= w_hit_next;
                r_fault_cnt <= w_fault_next;
                if (w_fault) begin
                    r_nff <= r_nff + 1'b1;
                end
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page   <= w_in_page;
            r_offset <= i_s_axis_tdata[OFFSET_BITS-1:0];
        end
        if (w_proceed) begin
            r_out_data <= {w_fault_next, w_hit_next, w_phys[15:0]};
            r_out_user <= {w_fault, w_lookup.hit};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESOLVE && r_out_valid && !i_m_axis_tready) |=> r_state == ST_RESOLVE)
        else $error("resolve left while result stalled");

    a_hit_xor_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("hit and fault flagged together");

    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proceed && w_lookup.hit) |=> r_hit_cnt == $past(r_hit_cnt) + 1'b1)
        else $error("hit total not advanced");

    a_fault_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proceed && w_fault) |=> r_nff == $past(r_nff) + 1'b1)
        else $error("free frame not advanced on fault");

    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_tbl_ready |-> !o_s_axis_tready)
        else $error("item accepted during table clear");

endmodule

### bench/tlb_lru_page_translator_checker.sv
`timescale 1ns / 1ps

module tlb_lru_page_translator_checker import tlpt_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [ADDR_BITS-1:0]   i_in_data,    // logical_address
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [79:0]            i_out_data,   // physical_address, hit_total, fault_total
    input  logic [1:0]             i_out_user,   // tlb_hit, page_fault
    output int                     o_mismatches,
    output int                     o_pending,
    output int                     o_results,
    output int                     o_hits,
    output int                     o_faults
);

    localparam int TLB_DEPTH   = 16;
    localparam int TABLE_DEPTH = 256;
    localparam int OFFSET_W    = 8;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  phys_addr;
        logic                  tlb_hit;
        logic                  page_fault;
        logic [COUNT_BITS-1:0] hit_total;
        logic [COUNT_BITS-1:0] fault_total;
    } t_xlat;

    logic [FRAME_BITS-1:0] tlb_page_q  [TLB_DEPTH];
    logic [FRAME_BITS-1:0] tlb_frame_q [TLB_DEPTH];
    logic                  tlb_valid_q [TLB_DEPTH];
    logic [3:0]            tlb_rank_q  [TLB_DEPTH];
    logic [FRAME_BITS-1:0] pt_frame    [TABLE_DEPTH];
    logic                  pt_valid    [TABLE_DEPTH];
    logic [NFF_BITS-1:0]   free_frame;
    logic [COUNT_BITS-1:0] hits_so_far;
    logic [COUNT_BITS-1:0] faults_so_far;

    t_xlat expected_q[$];
    t_xlat pred;
    t_xlat want;
    int    mismatch_count = 0;
    int    result_count   = 0;
    int    hit_count      = 0;
    int    fault_count    = 0;

    assign o_mismatches = mismatch_count;
    assign o_results    = result_count;
    assign o_hits       = hit_count;
    assign o_faults     = fault_count;

    function automatic void clear_translation_state();
        for (int j = 0; j < TLB_DEPTH; j++) begin
            tlb_valid_q[j] = 1'b0;
            tlb_rank_q[j]  = '0;
            tlb_page_q[j]  = '0;
            tlb_frame_q[j] = '0;
        end
        for (int j = 0; j < TABLE_DEPTH; j++) begin
            pt_valid[j] = 1'b0;
            pt_frame[j] = '0;
        end
        free_frame    = '0;
        hits_so_far   = '0;
        faults_so_far = '0;
    endfunction

    // entry k becomes most recently used, entries more recent than it age by one rank
    function automatic void promote_entry(input int k);
        logic       was_valid;
        logic [3:0] old_rank;
        was_valid = tlb_valid_q[k];
        old_rank  = tlb_rank_q[k];
        for (int j = 0; j < TLB_DEPTH; j++) begin
            if (j != k && tlb_valid_q[j] && (!was_valid || tlb_rank_q[j] < old_rank))
                tlb_rank_q[j] = tlb_rank_q[j] + 4'd1;
        end
        tlb_rank_q[k]  = '0;
        tlb_valid_q[k] = 1'b1;
    endfunction

    function automatic t_xlat translate_address(input logic [ADDR_BITS-1:0] laddr);
        logic [FRAME_BITS-1:0] pg;
        logic [OFFSET_W-1:0]   off;
        logic [FRAME_BITS-1:0] frm;
        logic                  hit;
        logic                  fault;
        logic                  found;
        int                    victim;
        t_xlat                 r;
        pg    = laddr[ADDR_BITS-1:OFFSET_W];
        off   = laddr[OFFSET_W-1:0];
        frm   = '0;
        hit   = 1'b0;
        fault = 1'b0;
        for (int j = 0; j < TLB_DEPTH; j++) begin
            if (!hit && tlb_valid_q[j] && tlb_page_q[j] == pg) begin
                hit = 1'b1;
                frm = tlb_frame_q[j];
                promote_entry(j);
            end
        end
        if (hit) begin
            hits_so_far = hits_so_far + 1;
        end else begin
            if (pt_valid[pg]) begin
                frm = pt_frame[pg];
            end else begin
                // frames are handed out in order and reused once the counter wraps
                fault         = 1'b1;
                frm           = free_frame[FRAME_BITS-1:0];
                free_frame    = free_frame + 1'b1;
                pt_frame[pg]  = frm;
                pt_valid[pg]  = 1'b1;
                faults_so_far = faults_so_far + 1;
            end
            // invalid entries first, lowest index, else the oldest rank
            found  = 1'b0;
            victim = 0;
            for (int j = 0; j < TLB_DEPTH; j++) begin
                if (!found && !tlb_valid_q[j]) begin
                    victim = j;
                    found  = 1'b1;
                end
            end
            if (!found) begin
                for (int j = 1; j < TLB_DEPTH; j++)
                    if (tlb_rank_q[j] > tlb_rank_q[victim])
                        victim = j;
            end
            tlb_page_q[victim]  = pg;
            tlb_frame_q[victim] = frm;
            promote_entry(victim);
        end
        r.phys_addr   = {frm, off};
        r.tlb_hit     = hit;
        r.page_fault  = fault;
        r.hit_total   = hits_so_far;
        r.fault_total = faults_so_far;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val) begin
            if (mismatch_count < 10)
                $display("mismatch in %s of result %0d: expected %h, got %h",
                         what, result_count, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_translation_state();
            expected_q.delete();
            o_pending <= 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                pred = translate_address(i_in_data);
                if (pred.tlb_hit)
                    hit_count++;
                if (pred.page_fault)
                    fault_count++;
                expected_q.push_back(pred);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_q.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("result %0d arrived with no item outstanding: %h %b",
                                 result_count, i_out_data, i_out_user);
                    mismatch_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("physical_address", 32'(want.phys_addr),
                                32'(i_out_data[15:0]));
                    check_field("tlb_hit", 32'(want.tlb_hit), 32'(i_out_user[0]));
                    check_field("page_fault", 32'(want.page_fault), 32'(i_out_user[1]));
                    check_field("hit_total", want.hit_total, i_out_data[47:16]);
                    check_field("fault_total", want.fault_total, i_out_data[79:48]);
                end
                result_count++;
            end
            o_pending <= expected_q.size();
        end
    end

endmodule

### bench/tlb_lru_page_translator_tb.sv
`timescale 1ns / 1ps

module tlb_lru_page_translator_tb import tlpt_pkg::*;;

    localparam int IDLE_LIMIT     = 5000;
    localparam int PHASE_ITEMS    = 175;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [ADDR_BITS-1:0] s_data  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [79:0]          m_data;   // physical_address, hit_total, fault_total
    logic [1:0]           m_user;   // tlb_hit, page_fault

    int mismatches;
    int pending;
    int results;
    int hits;
    int faults;

    int send_idle  = 0;
    int recv_stall = 0;
    int idle_cycles = 0;

    logic [7:0] hot_base;
    int         hot_size;
    logic [7:0] last_page = '0;
    logic [7:0] next_page;
    int         pick;

    tlb_lru_page_translator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    tlb_lru_page_translator_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_valid),
        .i_in_ready   (s_ready),
        .i_in_data    (s_data),
        .i_out_valid  (m_valid),
        .i_out_ready  (m_ready),
        .i_out_data   (m_data),
        .i_out_user   (m_user),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results),
        .o_hits       (hits),
        .o_faults     (faults)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("no item moved for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, pending);
                $display("[tlb_lru_page_translator] ERROR");
                $finish;
            end
        end
    end

    task automatic push_address(input logic [ADDR_BITS-1:0] addr);
        forever begin
            if ($urandom_range(0, 99) < send_idle) begin
                s_valid <= 1'b0;
                @(posedge i_clk);
            end else begin
                break;
            end
        end
        s_valid <= 1'b1;
        s_data  <= addr;
        do @(posedge i_clk); while (!s_ready);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extremes of page and offset, repeat hits on the same page
        push_address(16'h0000);
        push_address(16'h00ff);
        push_address(16'hffff);
        push_address(16'hff00);
        // fill every tlb entry, then one more to evict the oldest
        for (int p = 1; p <= 15; p++)
            push_address({p[7:0], 8'h3c});
        // evicted pages come back from the page table without a fault, then a resident page hits
        push_address(16'h0012);
        push_address(16'hff80);
        push_address(16'h0f01);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 67; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 67; end
                default: begin send_idle = 37; recv_stall = 37; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // a working set near the tlb size moves every few dozen items
                if (n % 40 == 0) begin
                    hot_base = 8'($urandom_range(0, 255));
                    hot_size = $urandom_range(4, 24);
                end
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    next_page = hot_base + 8'($urandom_range(0, hot_size - 1));
                else if (pick < 80)
                    next_page = last_page;
                else
                    next_page = 8'($urandom_range(0, 255));
                last_page = next_page;
                push_address({next_page, 8'($urandom_range(0, 255))});
            end
        end
        s_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);

        $display("translated %0d addresses with %0d tlb hits and %0d page faults",
                 results, hits, faults);
        $display("ran without idling, with sender gaps, receiver stalls and both");
        if (mismatches == 0 && pending == 0) begin
            $display("[tlb_lru_page_translator] OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("[tlb_lru_page_translator] ERROR");
        end
        $finish;
    end

endmodule

### files.f
rtl/tlpt_pkg.sv
rtl/tlpt_page_table.sv
rtl/tlpt_tlb.sv
rtl/tlb_lru_page_translator.sv
bench/tlb_lru_page_translator_checker.sv
bench/tlb_lru_page_translator_tb.sv
